[rtl/dsp_adpcm_frame_decoder_assert.svh]
// assertion macros for the adpcm frame decoder
// used by the top level only, needs no package
`ifndef DSP_ADPCM_FRAME_DECODER_ASSERT_SVH
`define DSP_ADPCM_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ADPCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adpcm assertion failed");

// next-cycle implication, checked out of reset
`define ADPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adpcm assertion failed");

`endif

[rtl/adpcm_pkg.sv]
// shared constants and types of the adpcm frame decoder
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package adpcm_pkg;

    localparam int HDR_W      = 8;
    localparam int PAY_W      = 56;
    localparam int IDX_W      = 4;
    localparam int NIB_W      = 4;
    localparam int SCALE_W    = 4;
    localparam int PCM_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PAIR_W     = 32;
    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_SEL_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int SAMPLES    = 14;
    localparam int ACC_W      = 34;
    localparam int FRAC_BITS  = 11;
    localparam int ROUND_BIAS = 1024;
    localparam int SHIFT_W    = 5;
    localparam int Q_W        = ACC_W - FRAC_BITS;

    typedef logic [PAIR_W-1:0] t_pair;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } t_state;

    // control word from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic en;      // update the accumulator
        logic load;    // start from the nibble term instead of the accumulator
        logic second;  // use c2 * older history instead of c1 * recent history
    } t_mac_ctl;

endpackage

`default_nettype wire

[rtl/adpcm_in_if.sv]
// frame input channel of the adpcm frame decoder
// depends on adpcm_pkg
`default_nettype none

interface adpcm_in_if import adpcm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HDR_W-1:0]     frame_header;
    logic [PAY_W-1:0]     frame_payload;
    logic [IDX_W-1:0]     start_index;
    logic [IDX_W-1:0]     num_samples;
    logic                 clear_history;

    modport source (
        output valid, frame_header, frame_payload, start_index, num_samples, clear_history,
        input  ready
    );
    modport sink (
        input  valid, frame_header, frame_payload, start_index, num_samples, clear_history,
        output ready
    );
endinterface

`default_nettype wire

[rtl/adpcm_out_if.sv]
// sample output channel of the adpcm frame decoder
// depends on adpcm_pkg
`default_nettype none

interface adpcm_out_if import adpcm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    last_of_frame;

    modport source (
        output valid, pcm_sample, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, pcm_sample, last_of_frame,
        output ready
    );
endinterface

`default_nettype wire

[rtl/adpcm_mac.sv]
// shared 16x16 signed multiply-accumulate unit of the adpcm decoder
// depends on adpcm_pkg
`default_nettype none

module adpcm_mac import adpcm_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [COEF_W-1:0] i_c1,
    input  logic signed [COEF_W-1:0] i_c2,
    input  logic signed [PCM_W-1:0]  i_h1,
    input  logic signed [PCM_W-1:0]  i_h2,
    input  logic signed [ACC_W-1:0]  i_base,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [COEF_W-1:0]       w_a;
    logic signed [PCM_W-1:0]        w_b;
    logic signed [COEF_W+PCM_W-1:0] w_prod;
    logic signed [ACC_W-1:0]        w_addend;
    logic signed [ACC_W-1:0]        n_acc;
    logic signed [ACC_W-1:0]        r_acc;

    always_comb begin
        w_a      = i_ctl.second ? i_c2 : i_c1;
        w_b      = i_ctl.second ? i_h2 : i_h1;
        w_prod   = w_a * w_b;
        w_addend = i_ctl.load ? i_base : r_acc;
        n_acc    = w_addend + ACC_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

[rtl/adpcm_ctl.sv]
// sample sequencer of the adpcm decoder: frame latch, history, clamp, output register
// depends on adpcm_pkg, adpcm_in_if, adpcm_out_if; drives adpcm_mac
`default_nettype none

module adpcm_ctl import adpcm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    adpcm_in_if.sink                 i_in,
    adpcm_out_if.source              o_out,
    input  t_pair                    i_coef [NUM_PAIRS],
    input  logic signed [ACC_W-1:0]  i_acc,
    output t_mac_ctl                 o_mac_ctl,
    output logic signed [COEF_W-1:0] o_c1,
    output logic signed [COEF_W-1:0] o_c2,
    output logic signed [PCM_W-1:0]  o_h1,
    output logic signed [PCM_W-1:0]  o_h2,
    output logic signed [ACC_W-1:0]  o_base
);

    t_state                   r_state, n_state;
    logic [PAY_W-1:0]         r_pay;
    logic [SCALE_W-1:0]       r_scale;
    logic signed [COEF_W-1:0] r_c1, r_c2;
    logic [IDX_W-1:0]         r_idx, r_end;
    logic signed [PCM_W-1:0]  r_h1, r_h2;
    logic                     r_out_valid;
    logic signed [PCM_W-1:0]  r_pcm;
    logic                     r_last;

    logic                     w_accept;
    logic                     w_active;
    logic [IDX_W:0]           w_sum;
    logic [IDX_W-1:0]         w_end;
    t_pair                    w_pair;
    logic [PAY_W-1:0]         w_pay_sh;
    logic signed [NIB_W-1:0]  w_nib;
    logic signed [ACC_W-1:0]  w_nib_ext;
    logic [SHIFT_W-1:0]       w_shamt;
    logic signed [Q_W-1:0]    w_q;
    logic signed [PCM_W-1:0]  w_pcm;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_emit;

    // frame bookkeeping at accept
    always_comb begin
        w_accept = i_in.valid && i_in.ready;
        w_sum    = {1'b0, i_in.start_index} + {1'b0, i_in.num_samples};
        w_end    = (w_sum > (IDX_W+1)'(SAMPLES)) ? IDX_W'(SAMPLES) : w_sum[IDX_W-1:0];
        w_active = (i_in.start_index < IDX_W'(SAMPLES)) && (i_in.num_samples != '0);
        w_pair   = i_coef[i_in.frame_header[PAIR_SEL_W+SCALE_W-1:SCALE_W]];
    end

    // nibble term plus rounding bias
    always_comb begin
        w_pay_sh  = r_pay << {r_idx, 2'b00};
        w_nib     = w_pay_sh[PAY_W-1 -: NIB_W];
        w_nib_ext = ACC_W'(w_nib);
        w_shamt   = {1'b0, r_scale} + SHIFT_W'(FRAC_BITS);
        o_base    = (w_nib_ext <<< w_shamt) + ACC_W'(ROUND_BIAS);
    end

    // floor shift and saturate to 16 bits
    always_comb begin
        w_q = i_acc[ACC_W-1:FRAC_BITS];
        if ((&w_q[Q_W-1:PCM_W-1]) || !(|w_q[Q_W-1:PCM_W-1])) begin
            w_pcm = w_q[PCM_W-1:0];
        end else begin
            w_pcm = {w_q[Q_W-1], {(PCM_W-1){~w_q[Q_W-1]}}};
        end
        w_last = ({1'b0, r_idx} + (IDX_W+1)'(1)) == {1'b0, r_end};
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state   = r_state;
        o_mac_ctl = '0;
        w_emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_active) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_mac_ctl.en   = 1'b1;
                o_mac_ctl.load = 1'b1;
                n_state        = ST_MUL2;
            end
            ST_MUL2: begin
                o_mac_ctl.en     = 1'b1;
                o_mac_ctl.second = 1'b1;
                n_state          = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = w_last ? ST_IDLE : ST_MUL1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1        <= '0;
            r_h2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && i_in.clear_history) begin
                r_h1 <= '0;
                r_h2 <= '0;
            end else if (w_emit) begin
                r_h2 <= r_h1;
                r_h1 <= w_pcm;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pay   <= i_in.frame_payload;
            r_scale <= i_in.frame_header[SCALE_W-1:0];
            r_c1    <= w_pair[PAIR_W-1:COEF_W];
            r_c2    <= w_pair[COEF_W-1:0];
            r_idx   <= i_in.start_index;
            r_end   <= w_end;
        end else if (w_emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (w_emit) begin
            r_pcm  <= w_pcm;
            r_last <= w_last;
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.pcm_sample    = r_pcm;
    assign o_out.last_of_frame = r_last;
    assign o_c1                = r_c1;
    assign o_c2                = r_c2;
    assign o_h1                = r_h1;
    assign o_h2                = r_h2;

endmodule

`default_nettype wire

[rtl/dsp_adpcm_frame_decoder.sv]
// one-channel adpcm frame decoder: coefficient registers, sequencer, shared mac
// depends on adpcm_pkg, adpcm_in_if, adpcm_out_if, adpcm_ctl, adpcm_mac,
// dsp_adpcm_frame_decoder_assert.svh
//
// usage
// - input channel i_in: one beat is one 8-byte frame (header, 56-bit payload)
//   plus start index, sample count and a clear-history flag
// - output channel o_out: one beat per decoded 16-bit sample, last_of_frame
//   marks the final sample of a frame
// - coefficient pairs are written through i_cfg_we / i_cfg_index / i_cfg_data
//   only while the block is idle, a rule for the user that the block does not
//   enforce; indexes past the eighth pair are dropped
// - each sample takes two passes through the single 16x16 multiply-accumulate
//   unit (c1 * recent, c2 * older) and one clamp/emit step; the input closes
//   after a beat that has samples to emit, ready returns after the last emit
// - a frame that emits nothing (start past the end or zero count) keeps the
//   input ready and only applies the history clear
// - a stalled receiver holds the emit step; the output register keeps its beat
//   and the decoder resumes when it drains
// - synchronous reset clears the coefficients, both history samples and the
//   output valid
`default_nettype none

`include "dsp_adpcm_frame_decoder_assert.svh"

module dsp_adpcm_frame_decoder import adpcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    adpcm_in_if.sink             i_in,
    adpcm_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data
);

    // coefficient pair registers
    t_pair r_coef [NUM_PAIRS];

    // sequencer to mac wiring
    t_mac_ctl                 w_mac_ctl;
    logic signed [COEF_W-1:0] w_c1, w_c2;
    logic signed [PCM_W-1:0]  w_h1, w_h2;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  w_acc;

    // input handshake terms for the checks
    logic                     w_in_beat;
    logic                     w_in_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
            r_coef[i_cfg_index[PAIR_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    adpcm_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_coef    (r_coef),
        .i_acc     (w_acc),
        .o_mac_ctl (w_mac_ctl),
        .o_c1      (w_c1),
        .o_c2      (w_c2),
        .o_h1      (w_h1),
        .o_h2      (w_h2),
        .o_base    (w_base)
    );

    adpcm_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_c1   (w_c1),
        .i_c2   (w_c2),
        .i_h1   (w_h1),
        .i_h2   (w_h2),
        .i_base (w_base),
        .o_acc  (w_acc)
    );

    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_in_empty = (i_in.start_index >= IDX_W'(SAMPLES)) || (i_in.num_samples == '0);

    // a frame with nothing to emit leaves the input open
    `ADPCM_ASSERT_NEXT(a_empty_frame_ready, i_clk, i_rst_n, w_in_beat && w_in_empty, i_in.ready)

    // a frame with work closes the input in the next cycle
    `ADPCM_ASSERT_NEXT(a_busy_after_frame, i_clk, i_rst_n, w_in_beat && !w_in_empty, !i_in.ready)

    // a pending mid-frame sample means the frame is still in progress
    `ADPCM_ASSERT_NOW(a_mid_frame_busy, i_clk, i_rst_n, o_out.valid && !o_out.last_of_frame, !i_in.ready)

endmodule

`default_nettype wire

[tb/tb_dsp_adpcm_frame_decoder.sv]
// self-checking testbench for dsp_adpcm_frame_decoder: random and directed frames
// depends on adpcm_pkg, adpcm_in_if, adpcm_out_if and the decoder rtl
`timescale 1ns / 1ps

module tb_dsp_adpcm_frame_decoder import adpcm_pkg::*; ();

    // register map: pair k sits at index k, everything past the last pair is dropped
    localparam int CFG_COEF_PAIR_0  = 0;
    localparam int CFG_UNMAPPED_LOW = NUM_PAIRS;
    localparam int CFG_UNMAPPED_TOP = (1 << CFG_IDX_W) - 1;

    localparam int CYCLE_LIMIT = 500000;  // several times the slowest legal run
    localparam int IDLE_TAIL   = 12;

    // one input beat
    typedef struct {
        logic [HDR_W-1:0] hdr;
        logic [PAY_W-1:0] payload;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] count;
        logic             clear;
    } t_frame;

    // one output beat
    typedef struct {
        logic signed [PCM_W-1:0] pcm;
        logic                    is_last;
    } t_sample_beat;

    // decoder model plus the queue of samples it still owes
    class adpcm_scoreboard;
        t_pair                   coef [NUM_PAIRS];
        logic signed [PCM_W-1:0] hist_recent;
        logic signed [PCM_W-1:0] hist_older;
        t_sample_beat            expected_samples [$];
        int                      fails;

        function new();
            foreach (coef[k]) coef[k] = '0;
            hist_recent = '0;
            hist_older  = '0;
            fails       = 0;
        endfunction

        function void set_coef(int index, t_pair value);
            if (index < NUM_PAIRS) coef[index] = value;
        endfunction

        // decode one accepted frame into the samples it must produce
        function void note_frame(t_frame f);
            logic signed [COEF_W-1:0] c1;
            logic signed [COEF_W-1:0] c2;
            logic signed [NIB_W-1:0]  nib;
            longint                   acc;
            longint                   smp;
            int                       first;
            int                       n;
            t_sample_beat             beat;
            // header bit 7 plays no part in the pair select
            c1 = coef[f.hdr[6:4]][PAIR_W-1:COEF_W];
            c2 = coef[f.hdr[6:4]][COEF_W-1:0];
            // the clear applies even when nothing gets emitted
            if (f.clear) begin
                hist_recent = '0;
                hist_older  = '0;
            end
            first = int'(f.start);
            n     = int'(f.count);
            if (first >= SAMPLES) return;
            if (n > SAMPLES - first) n = SAMPLES - first;
            for (int i = first; i < first + n; i++) begin
                nib = f.payload[PAY_W-1-NIB_W*i -: NIB_W];
                acc = (longint'(nib) <<< (f.hdr[3:0] + FRAC_BITS)) + ROUND_BIAS
                    + longint'(c1) * longint'(hist_recent)
                    + longint'(c2) * longint'(hist_older);
                smp = acc >>> FRAC_BITS;
                if (smp > 32767) smp = 32767;
                if (smp < -32768) smp = -32768;
                hist_older   = hist_recent;
                hist_recent  = PCM_W'(smp);
                beat.pcm     = PCM_W'(smp);
                beat.is_last = (i == first + n - 1);
                expected_samples.push_back(beat);
            end
        endfunction

        function void check_sample(logic signed [PCM_W-1:0] pcm, logic is_last);
            t_sample_beat want;
            if (expected_samples.size() == 0) begin
                $error("pcm_sample beat with nothing expected: actual %0d", pcm);
                fails++;
                return;
            end
            want = expected_samples.pop_front();
            if (pcm !== want.pcm) begin
                $error("pcm_sample mismatch: expected %0d actual %0d", want.pcm, pcm);
                fails++;
            end
            if (is_last !== want.is_last) begin
                $error("last_of_frame mismatch: expected %0b actual %0b",
                       want.is_last, is_last);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PAIR_W-1:0] i_cfg_data;

    adpcm_in_if  in_ch ();
    adpcm_out_if out_ch ();

    adpcm_scoreboard sb;

    int burst_left = 1;   // beats left in the current sender burst
    int rx_mode;          // receiver stall pattern
    int rx_mode_left = 0;
    int rx_tick = 0;
    int cycles = 0;

    dsp_adpcm_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: every accepted beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_sample(out_ch.pcm_sample, out_ch.last_of_frame);
    end

    // receiver stalls: always ready, coin flip, mostly stalled, or a long periodic stall
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 256);
            rx_tick      = 0;
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = 1'($urandom_range(0, 1));
            2: out_ch.ready = ($urandom_range(0, 3) == 0);
            default: out_ch.ready = ((rx_tick % 11) < 2);
        endcase
    end

    function automatic t_frame mk(logic [HDR_W-1:0] hdr, logic [PAY_W-1:0] payload,
                                  int start, int count, logic clear);
        t_frame f;
        f.hdr     = hdr;
        f.payload = payload;
        f.start   = IDX_W'(start);
        f.count   = IDX_W'(count);
        f.clear   = clear;
        return f;
    endfunction

    function automatic logic [PAY_W-1:0] rand_payload();
        return PAY_W'({$urandom, $urandom});
    endfunction

    // coefficients in the range real encoders produce, so the history stays lively
    function automatic t_pair realistic_pair();
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        c1 = COEF_W'(int'($urandom_range(0, 6143)) - 2048);
        c2 = COEF_W'(-int'($urandom_range(0, 2048)));
        return {c1, c2};
    endfunction

    function automatic t_pair extreme_pair();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_8000;
            1:       return 32'h8000_7FFF;
            2:       return 32'h7FFF_7FFF;
            3:       return 32'h8000_8000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // all drive tasks start and end at a falling edge
    task automatic write_cfg(int index, logic [PAIR_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_IDX_W'(index);
        i_cfg_data  = data;
        sb.set_coef(index, data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // one input beat, then the burst/gap pacing of the sender
    task automatic send_frame(t_frame f);
        int gap;
        in_ch.valid         = 1'b1;
        in_ch.frame_header  = f.hdr;
        in_ch.frame_payload = f.payload;
        in_ch.start_index   = f.start;
        in_ch.num_samples   = f.count;
        in_ch.clear_history = f.clear;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_frame(f);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid         = 1'b0;
                in_ch.frame_payload = rand_payload();
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // hold the sender until the decoder has delivered everything it owes
    task automatic wait_drained();
        while (sb.expected_samples.size() != 0) @(negedge i_clk);
        repeat (IDLE_TAIL) @(negedge i_clk);
    endtask

    task automatic run_directed();
        // silence with a clear, then full-scale positive and negative against pair 0
        send_frame(mk(8'h00, 56'h00000000000000, 0, 14, 1'b1));
        send_frame(mk(8'h0F, 56'h77777777777777, 0, 14, 1'b0));
        send_frame(mk(8'h0F, 56'h88888888888888, 0, 14, 1'b0));
        send_frame(mk(8'h10, 56'hFFFFFFFFFFFFFF, 0, 14, 1'b1));
        // header bit 7 set: must still pick pair 3
        send_frame(mk(8'hB5, 56'h0123456789ABCD, 0, 14, 1'b0));
        for (int p = 0; p < NUM_PAIRS; p++)
            send_frame(mk({1'b0, PAIR_SEL_W'(p), SCALE_W'($urandom_range(0, 15))},
                          rand_payload(), 0, 14, 1'b0));
        // count running past the frame end gets trimmed
        send_frame(mk(8'h47, rand_payload(), 13, 14, 1'b0));
        send_frame(mk(8'h47, rand_payload(), 5, 15, 1'b0));
        // start beyond the frame: nothing out, history kept
        send_frame(mk(8'h47, rand_payload(), 14, 3, 1'b0));
        // same, but the clear still lands
        send_frame(mk(8'h47, rand_payload(), 15, 15, 1'b1));
        send_frame(mk(8'h47, rand_payload(), 0, 14, 1'b0));
        // zero count: nothing out
        send_frame(mk(8'h47, rand_payload(), 3, 0, 1'b0));
        send_frame(mk(8'h47, rand_payload(), 2, 4, 1'b0));
        // zero count with clear, then a single sample shows the cleared history
        send_frame(mk(8'hE2, rand_payload(), 0, 0, 1'b1));
        send_frame(mk(8'h3C, rand_payload(), 0, 1, 1'b0));
    endtask

    // whole frames half the time, as a real stream would send, the rest odd windows
    task automatic run_random(int n_items);
        t_frame f;
        for (int k = 0; k < n_items; k++) begin
            f.hdr     = HDR_W'($urandom_range(0, 255));
            f.payload = rand_payload();
            f.clear   = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    f.start = IDX_W'(0);
                    f.count = IDX_W'(14);
                end
                5: begin
                    f.start = IDX_W'($urandom_range(0, 15));
                    f.count = IDX_W'($urandom_range(0, 15));
                end
                default: begin
                    f.start = IDX_W'($urandom_range(0, 13));
                    f.count = IDX_W'($urandom_range(1, 15));
                end
            endcase
            send_frame(f);
            // one pause mid-stream until the decoder catches up
            if (k == n_items / 2) begin
                in_ch.valid = 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.frame_header  = '0;
        in_ch.frame_payload = '0;
        in_ch.start_index   = '0;
        in_ch.num_samples   = '0;
        in_ch.clear_history = 1'b0;
        out_ch.ready        = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // extremes on the low pairs, unity gain on pair 3, realistic on the rest
        write_cfg(CFG_COEF_PAIR_0 + 0, 32'h7FFF_8000);
        write_cfg(CFG_COEF_PAIR_0 + 1, 32'h8000_7FFF);
        write_cfg(CFG_COEF_PAIR_0 + 2, 32'h0000_0000);
        write_cfg(CFG_COEF_PAIR_0 + 3, 32'h0800_0000);
        for (int p = 4; p < NUM_PAIRS; p++)
            write_cfg(CFG_COEF_PAIR_0 + p, realistic_pair());
        run_directed();
        in_ch.valid = 1'b0;
        wait_drained();

        // arbitrary bit patterns in every pair
        for (int p = 0; p < NUM_PAIRS; p++)
            write_cfg(CFG_COEF_PAIR_0 + p, {$urandom});
        run_random(60);
        in_ch.valid = 1'b0;
        wait_drained();

        // realistic predictors, the bulk of the run
        for (int p = 0; p < NUM_PAIRS; p++)
            write_cfg(CFG_COEF_PAIR_0 + p, realistic_pair());
        run_random(120);
        in_ch.valid = 1'b0;
        wait_drained();

        // saturating pairs; unmapped indexes must leave them alone
        for (int p = 0; p < NUM_PAIRS; p++)
            write_cfg(CFG_COEF_PAIR_0 + p, extreme_pair());
        for (int idx = CFG_UNMAPPED_LOW; idx <= CFG_UNMAPPED_TOP; idx++)
            write_cfg(idx, {$urandom});
        run_random(40);
        in_ch.valid = 1'b0;
        wait_drained();

        if (sb.expected_samples.size() != 0) begin
            $error("samples never delivered: %0d", sb.expected_samples.size());
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
